// ----- hw/rtl/rmmmv_pkg.sv -----
// ----------------------------------------------------------------------------
// rmmmv_pkg: shared types and constants for the running statistics unit
// Field widths of the sample and result streams, the Q8 format and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmmv_pkg;

  // Field widths of the streams
  parameter int unsigned SampleW = 16;
  parameter int unsigned MeanW   = 24;
  parameter int unsigned VarW    = 39;
  parameter int unsigned CountW  = 9;

  // Fraction bits of the mean and variance results
  parameter int unsigned FracW = 8;

  // Packed result width: max, min, mean, variance, count
  parameter int unsigned OutDataW = 2 * SampleW + MeanW + VarW + CountW;

  // Default set length limit
  parameter int unsigned DefaultMaxCount = 256;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_PREP,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_DIV_M,
    S_DIV_V,
    S_LOAD
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/running_min_max_mean_variance_unit.sv -----
// ----------------------------------------------------------------------------
// running_min_max_mean_variance_unit: per-set max, min, mean and variance
// Accumulates signed samples and reports Q8 mean and population variance.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_axis_tdata carries one signed 16-bit sample, s_axis_tlast
//   marks the last sample of a set. A sample is accepted in S_IDLE and
//   accumulated in S_ACC; the slave side is not ready until it is accumulated.
//   Samples past MAX_COUNT in one set are not accumulated; the overflow flag
//   of that set's result is raised.
//   Master stream: one transaction per set, sent after the sample with tlast.
//   The final figures come from one bit-serial multiplier and one bit-serial
//   divider. After the last sample, the sequencer forms n*sumsq, sum^2 and
//   n^2 on the multiplier, then divides for the mean and the variance, and
//   then loads the result. The slave side is not ready meanwhile.
//   The result sits in an output register: the next set is accepted while it
//   waits. When a second result is done before the first one is taken, the
//   unit holds it and stays not ready until the master side frees.
//   Reset clears all accumulators and drops any result that was not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module running_min_max_mean_variance_unit
  import rmmmv_pkg::*;
#(
  parameter int unsigned MAX_COUNT = DefaultMaxCount
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Sample stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SampleW-1:0]   s_axis_tdata,   // [15:0] sample
  input  wire logic                 s_axis_tlast,   // last sample of the set
  // Result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [15:0] max_value, [31:16] min_value, [55:32] mean_q8,
  // [94:56] variance_q8, [103:95] count
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic                      m_axis_tuser    // [0] overflow
);

  localparam int unsigned CntW  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SumW  = CntW + SampleW;
  localparam int unsigned MagW  = SumW - 1;
  localparam int unsigned SqW   = CntW + 2 * SampleW - 1;
  localparam int unsigned DvW   = CntW + SqW;
  localparam int unsigned NumW  = DvW + FracW + 2;
  localparam int unsigned DenW  = 2 * CntW + 1;
  localparam int unsigned MulAW = SqW;
  localparam int unsigned MulBW = MagW;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_COUNT);

  state_e state_q, state_d;

  // Accepted sample
  logic signed [SampleW-1:0]   sample_q;
  logic                        last_q;

  // Accumulators
  logic signed [SampleW-1:0]   max_q;
  logic signed [SampleW-1:0]   min_q;
  logic signed [SumW-1:0]      sum_q;
  logic [SqW-1:0]              sumsq_q;
  logic [CntW-1:0]             count_q;
  logic                        ovf_q;

  // Intermediate results
  logic [DvW-1:0]              nsq_q;
  logic [DvW-1:0]              dev_q;
  logic [2*CntW-1:0]           n2_q;
  logic [MeanW-1:0]            mean_mag_q;

  // Output register
  logic                        out_valid_q;
  logic [OutDataW-1:0]         out_data_q;
  logic                        out_ovf_q;

  logic                        out_free;
  logic                        load;
  logic signed [2*SampleW-1:0] square;
  logic [SumW-1:0]             sum_abs;
  logic [MagW-1:0]             mag;

  logic                        mul_start;
  logic [MulAW-1:0]            mul_a;
  logic [MulBW-1:0]            mul_b;
  logic                        mul_busy;
  logic [MulPW-1:0]            mul_prod;

  logic                        div_start;
  logic [NumW-1:0]             div_num;
  logic [DenW-1:0]             div_den;
  logic                        div_busy;
  logic [NumW-1:0]             div_quo;

  logic [SampleW-1:0]          max_field;
  logic [SampleW-1:0]          min_field;
  logic [MeanW-1:0]            mean_field;
  logic [VarW-1:0]             var_field;

  assign square  = sample_q * sample_q;
  assign sum_abs = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
  assign mag     = sum_abs[MagW-1:0];

  assign out_free = !out_valid_q || m_axis_tready;
  assign load     = (state_q == S_LOAD) && out_free;

  // Shared serial units
  rmmmv_mul #(
    .AW (MulAW),
    .BW (MulBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  rmmmv_div #(
    .NW (NumW),
    .DW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Sequence: n*sumsq, sum^2, n^2, then mean and variance divisions
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = last_q ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        if (count_q == '0) begin
          state_d = S_LOAD;
        end else begin
          mul_start = 1'b1;
          mul_a     = sumsq_q;
          mul_b     = MulBW'(count_q);
          state_d   = S_MUL_A;
        end
      end
      S_MUL_A: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(mag);
          mul_b     = mag;
          state_d   = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(count_q);
          mul_b     = MulBW'(count_q);
          state_d   = S_MUL_C;
        end
      end
      S_MUL_C: begin
        if (!mul_busy) begin
          div_start = 1'b1;
          div_num   = NumW'({mag, {(FracW + 1){1'b0}}}) + NumW'(count_q);
          div_den   = DenW'({count_q, 1'b0});
          state_d   = S_DIV_M;
        end
      end
      S_DIV_M: begin
        if (!div_busy) begin
          div_start = 1'b1;
          div_num   = NumW'({dev_q, {(FracW + 1){1'b0}}}) + NumW'(n2_q);
          div_den   = {n2_q, 1'b0};
          state_d   = S_DIV_V;
        end
      end
      S_DIV_V: begin
        if (!div_busy) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accumulate one sample, drop it once the set is full, clear on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= {1'b1, {(SampleW - 1){1'b0}}};
      min_q   <= {1'b0, {(SampleW - 1){1'b1}}};
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (load) begin
      max_q   <= {1'b1, {(SampleW - 1){1'b0}}};
      min_q   <= {1'b0, {(SampleW - 1){1'b1}}};
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (state_q == S_ACC) begin
      if (count_q == MaxCnt) begin
        ovf_q <= 1'b1;
      end else begin
        if (sample_q > max_q) begin
          max_q <= sample_q;
        end
        if (sample_q < min_q) begin
          min_q <= sample_q;
        end
        sum_q   <= sum_q + {{(SumW - SampleW){sample_q[SampleW-1]}}, sample_q};
        sumsq_q <= sumsq_q + {{(SqW - 2 * SampleW){1'b0}}, square};
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Capture the sample and the intermediate products
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && s_axis_tvalid) begin
      sample_q <= s_axis_tdata;
      last_q   <= s_axis_tlast;
    end
    if ((state_q == S_MUL_A) && !mul_busy) begin
      nsq_q <= mul_prod[DvW-1:0];
    end
    if ((state_q == S_MUL_B) && !mul_busy) begin
      dev_q <= nsq_q - mul_prod[DvW-1:0];
    end
    if ((state_q == S_MUL_C) && !mul_busy) begin
      n2_q <= mul_prod[2*CntW-1:0];
    end
    if ((state_q == S_DIV_M) && !div_busy) begin
      mean_mag_q <= div_quo[MeanW-1:0];
    end
  end

  // Result fields; an empty set reports zeros
  always_comb begin
    if (count_q == '0) begin
      max_field  = '0;
      min_field  = '0;
      mean_field = '0;
      var_field  = '0;
    end else begin
      max_field  = max_q;
      min_field  = min_q;
      mean_field = sum_q[SumW-1] ? (~mean_mag_q + MeanW'(1)) : mean_mag_q;
      var_field  = div_quo[VarW-1:0];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {CountW'(count_q), var_field, mean_field, min_field, max_field};
      out_ovf_q  <= ovf_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rmmmv_mul.sv -----
// ----------------------------------------------------------------------------
// rmmmv_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle; the product is stable once busy drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmmv_mul
  import rmmmv_pkg::*;
#(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic                  busy_o,
  output logic [AW+BW-1:0]      prod_o
);

  localparam int unsigned PW   = AW + BW;
  localparam int unsigned CntW = (BW > 1) ? $clog2(BW) : 1;

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]    a_q;
  logic [PW-1:0]    prod_q, prod_d;
  logic [AW:0]      upper_sum;

  // Add the multiplicand into the upper half when the low bit is set
  assign upper_sum = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(BW - 1);
      prod_d = {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_d = {upper_sum, prod_q[BW-1:1]};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and product shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    prod_q <= prod_d;
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rmmmv_div.sv -----
// ----------------------------------------------------------------------------
// rmmmv_div: bit-serial restoring divider
// Shifts in one numerator bit per cycle and retires one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmmv_div
  import rmmmv_pkg::*;
#(
  parameter int unsigned NW = 59,
  parameter int unsigned DW = 19
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DW-1:0]  den_i,
  output logic                busy_o,
  output logic [NW-1:0]       quo_o
);

  localparam int unsigned CntW = (NW > 1) ? $clog2(NW) : 1;

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]    den_q;
  logic [DW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW:0]      cand;
  logic [DW:0]      diff;
  logic             fits;

  // Trial subtraction of the divisor from the shifted remainder
  assign cand = {rem_q, quo_q[NW-1]};
  assign diff = cand - {1'b0, den_q};
  assign fits = (cand >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NW - 1);
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DW-1:0] : cand[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Divisor, remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- sim/tb_running_min_max_mean_variance_unit.sv -----
// ----------------------------------------------------------------------------
// tb_running_min_max_mean_variance_unit: self-checking bench for the stats unit
// Streams sets of signed samples into the unit under bursty traffic. A
// scoreboard recomputes max, min, rounded Q8 mean and variance, count and the
// overflow flag of each set, and compares every result transaction with them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_running_min_max_mean_variance_unit
  import rmmmv_pkg::*;
;

  localparam int unsigned MaxCount    = DefaultMaxCount;
  localparam int unsigned ItemTarget  = 1150;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldAfter   = 20;
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned TailCycles  = 250;
  localparam int unsigned DirectedLen = 21;

  // One result transaction: tuser on top, then tdata from its highest field down
  typedef struct packed {
    logic               overflow;
    logic [CountW-1:0]  count;
    logic [VarW-1:0]    variance_q8;
    logic [MeanW-1:0]   mean_q8;
    logic [SampleW-1:0] min_value;
    logic [SampleW-1:0] max_value;
  } set_stats_t;

  // Running statistics of the open set and the results still owed
  class set_stats_scoreboard;
    logic signed [SampleW-1:0] run_max;
    logic signed [SampleW-1:0] run_min;
    logic signed [MeanW-1:0]   run_sum;
    logic [VarW-1:0]           run_square_sum;
    logic [CountW-1:0]         run_count;
    logic                      run_dropped;
    set_stats_t                owed_q[$];
    int unsigned               errors;
    int unsigned               checked;

    function new();
      clear_set();
    endfunction

    function void clear_set();
      run_max        = {1'b1, {(SampleW-1){1'b0}}};
      run_min        = {1'b0, {(SampleW-1){1'b1}}};
      run_sum        = '0;
      run_square_sum = '0;
      run_count      = '0;
      run_dropped    = 1'b0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
               checked, what, want, got);
    endtask

    // Accumulate one accepted sample; close the set on the last one
    function void note_sample(logic [SampleW-1:0] value, logic last_flag);
      logic signed [SampleW-1:0] s;
      logic signed [31:0]        sq;
      longint                    sum64;
      longint unsigned           mag, cnt, q, d, n2;
      set_stats_t                res;
      s = value;
      if (run_count >= MaxCount) begin
        run_dropped = 1'b1;
      end else begin
        if (s > run_max) run_max = s;
        if (s < run_min) run_min = s;
        sq             = s * s;
        run_sum        = run_sum + s;
        run_square_sum = run_square_sum + sq;
        run_count      = run_count + 1'b1;
      end
      if (!last_flag) return;

      res          = '0;
      res.count    = run_count;
      res.overflow = run_dropped;
      if (run_count != 0) begin
        res.max_value = run_max;
        res.min_value = run_min;
        // Mean rounds half away from zero, computed on the magnitude
        sum64 = run_sum;
        mag   = (sum64 < 0) ? -sum64 : sum64;
        cnt   = run_count;
        q     = (2 * mag * 256 + cnt) / (2 * cnt);
        res.mean_q8 = (sum64 < 0) ? (64'd0 - q) : q;
        // Variance: exact quotient, fraction rounded half up
        d  = cnt * run_square_sum - mag * mag;
        n2 = cnt * cnt;
        res.variance_q8 = (d / n2) * 256 + (512 * (d % n2) + n2) / (2 * n2);
      end
      owed_q.push_back(res);
      clear_set();
    endfunction

    // Compare one result transaction with the oldest owed result
    task check_result(set_stats_t got);
      set_stats_t want;
      checked++;
      if (owed_q.size() == 0) begin
        report("unexpected transaction, count", 64'd0, got.count);
        return;
      end
      want = owed_q.pop_front();
      if (got.max_value !== want.max_value)
        report("max_value", want.max_value, got.max_value);
      if (got.min_value !== want.min_value)
        report("min_value", want.min_value, got.min_value);
      if (got.mean_q8 !== want.mean_q8)
        report("mean_q8", want.mean_q8, got.mean_q8);
      if (got.variance_q8 !== want.variance_q8)
        report("variance_q8", want.variance_q8, got.variance_q8);
      if (got.count !== want.count)
        report("count", want.count, got.count);
      if (got.overflow !== want.overflow)
        report("overflow", want.overflow, got.overflow);
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;   // [15:0] sample
  logic                s_axis_tlast  = 1'b0; // last sample of the set
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [15:0] max_value, [31:16] min_value, [55:32] mean_q8,
  // [94:56] variance_q8, [103:95] count
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;         // [0] overflow

  set_stats_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned results_seen;
  int unsigned hold_left;
  int unsigned sink_cycle;
  int unsigned idle_count;
  bit          held_once;

  // Directed sets: lone extremes, zero, mixed signs, rounding of negative means
  int dir_value [DirectedLen] = '{32767, -32768, 0, -32768, 32767, 1, 2, -1, -2, -2,
                                  5, -7, 3, 0, 1, -32768, -32768, -32768,
                                  32767, 32767, 32767};
  bit dir_last  [DirectedLen] = '{1, 1, 1, 0, 1, 0, 1, 0, 0, 1,
                                  0, 0, 0, 0, 1, 0, 0, 1,
                                  0, 0, 1};

  running_min_max_mean_variance_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Pick a sample: extremes, small values around zero, or any value
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SampleW-1){1'b0}}};
      1:       return {1'b0, {(SampleW-1){1'b1}}};
      2, 3:    return SampleW'($urandom_range(0, 32)) - SampleW'(16);
      default: return SampleW'($urandom());
    endcase
  endfunction

  // Offer one sample in the current burst and hold it until accepted
  task automatic send_sample(input logic [SampleW-1:0] value, input logic last_flag);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                        : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last_flag;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(value, last_flag);
    items_sent++;
  endtask

  // Send one set, either random samples or alternating extremes
  task automatic send_set(input int unsigned len, input bit alternate);
    logic [SampleW-1:0] value;
    for (int unsigned i = 0; i < len; i++) begin
      if (alternate) value = i[0] ? {1'b0, {(SampleW-1){1'b1}}} : {1'b1, {(SampleW-1){1'b0}}};
      else           value = pick_sample();
      send_sample(value, i == len - 1);
    end
  endtask

  // Random sets, mostly short, until the item count reaches a mark
  task automatic send_random_sets(input int unsigned mark);
    while (items_sent < mark) begin
      if ($urandom_range(0, 9) == 0) send_set($urandom_range(13, 60), 1'b0);
      else                           send_set($urandom_range(1, 12), 1'b0);
    end
  endtask

  // Pause the sample stream until every owed result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: check each transaction; rotating stalls plus one long hold
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result({m_axis_tuser, m_axis_tdata});
      results_seen++;
    end
    sink_cycle++;
    if (!held_once && results_seen == HoldAfter) begin
      held_once = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((sink_cycle / 97) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
        default: m_axis_tready <= (sink_cycle % 5 != 0);
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed sets, random sets with two long sets in between
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedLen; i++) send_sample(SampleW'(dir_value[i]), dir_last[i]);
    drain_results();

    send_random_sets(300);
    drain_results();
    // Full-length set of alternating extremes: largest variance, no overflow
    send_set(MaxCount, 1'b1);
    send_random_sets(650);
    // Overlong set: tail samples are dropped, the last one among them
    send_set(MaxCount + $urandom_range(1, 12), 1'b0);
    send_random_sets(ItemTarget);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
